/* hdl/mlsq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlsq_pkg
// Shared constants, types and helpers of the multilevel sorted ready queue.
// ----------------------------------------------------------------------------
package mlsq_pkg;

    // Queue geometry.
    localparam int LEVELS    = 3;
    localparam int CAPACITY  = 16;
    localparam int TIME_BITS = 8;

    // Fixed widths of the channel fields.
    localparam int PRI_W      = 5;
    localparam int TIME_IN_W  = 8;
    localparam int LEVEL_IN_W = 2;
    localparam int STATUS_W   = 3;

    // Derived widths.
    localparam int TW     = (TIME_BITS < TIME_IN_W) ? TIME_BITS : TIME_IN_W;
    localparam int DEPTH  = LEVELS * CAPACITY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LV_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int MEM_W  = PRI_W + TW;

    // Priority bands.
    localparam int BAND0_LO = 1;
    localparam int BAND0_HI = 10;
    localparam int BAND1_LO = 11;
    localparam int BAND1_HI = 20;
    localparam int BAND2_LO = 21;
    localparam int BAND2_HI = 30;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        RESP_ADDED = 3'd0,
        RESP_RANGE = 3'd1,
        RESP_FULL  = 3'd2,
        RESP_READ  = 3'd3,
        RESP_EMPTY = 3'd4
    } resp_t;

    // Input action codes.
    typedef enum logic {
        ACT_INSERT  = 1'b0,
        ACT_READOUT = 1'b1
    } action_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_CMP,
        S_INS_PUT,
        S_RD_EMIT,
        S_RESP
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic ins_first;
        logic shift;
        logic place_above;
        logic place_at;
        logic rd_first;
        logic rd_emit;
        logic resp_emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_insert;
        logic lvl_ok;
        logic full;
        logic empty;
        logic greater;
        logic pos_zero;
        logic rd_last;
        logic out_free;
    } sts_t;

    // Level lookup result for a priority.
    typedef struct packed {
        logic            ok;
        logic [LV_W-1:0] lv;
    } lvl_sel_t;

    // Map a priority to its level; ok is low when the priority fits no level.
    function automatic lvl_sel_t level_of(input logic [PRI_W-1:0] p);
        lvl_sel_t r;
        int       v;
        int       lv;
        v  = int'(p);
        lv = 0;
        r.ok = 1'b1;
        if (v >= BAND0_LO && v <= BAND0_HI)
        begin
            lv = 0;
        end
        else if (v >= BAND1_LO && v <= BAND1_HI)
        begin
            lv = 1;
        end
        else if (v >= BAND2_LO && v <= BAND2_HI)
        begin
            lv = 2;
        end
        else
        begin
            r.ok = 1'b0;
        end
        if (lv >= LEVELS)
        begin
            r.ok = 1'b0;
            lv   = 0;
        end
        r.lv = LV_W'(lv);
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/mlsq_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlsq_in_if / mlsq_out_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface mlsq_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [mlsq_pkg::PRI_W-1:0]      priority_req;
    logic [mlsq_pkg::TIME_IN_W-1:0]  exec_time;
    logic [mlsq_pkg::LEVEL_IN_W-1:0] level;

    modport source (output valid, output action, output priority_req,
                    output exec_time, output level, input ready);
    modport sink   (input valid, input action, input priority_req,
                    input exec_time, input level, output ready);
endinterface

interface mlsq_out_if;
    logic                           valid;
    logic                           ready;
    logic [mlsq_pkg::STATUS_W-1:0]  status;
    logic [mlsq_pkg::PRI_W-1:0]     entry_priority;
    logic [mlsq_pkg::TIME_IN_W-1:0] entry_time;
    logic                           last;

    modport source (output valid, output status, output entry_priority,
                    output entry_time, output last, input ready);
    modport sink   (input valid, input status, input entry_priority,
                    input entry_time, input last, output ready);
endinterface
`default_nettype wire

/* hdl/multilevel_sorted_ready_queue_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_sorted_ready_queue_top
// Three-level ready queue with sorted insert and in-order level readout.
// ----------------------------------------------------------------------------
// The block takes one request at a time. An insert of a task into a level
// walks from the tail of the level, moving one entry per cycle through the
// one read port and the one write port of the entry memory, and stops
// early at the first entry whose priority is not above the new one. A
// readout of a level delivers one result per cycle while the sink keeps
// ready high. Entries beyond each level's fill count are never read, so
// the memory needs no clearing pass after reset. A new request is taken
// only once the previous one has produced its last result; that result
// may still sit in the output register.
module multilevel_sorted_ready_queue_top (
    input wire logic clk,
    input wire logic rst_n,
    mlsq_in_if.sink  in_ch,
    mlsq_out_if.source out_ch
);
    import mlsq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Controller.
    mlsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    mlsq_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_action    (in_ch.action),
        .in_priority  (in_ch.priority_req),
        .in_time      (in_ch.exec_time),
        .in_level     (in_ch.level),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_status   (out_ch.status),
        .out_priority (out_ch.entry_priority),
        .out_time     (out_ch.entry_time),
        .out_last     (out_ch.last)
    );

    // A transfer on the input is never followed directly by another.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("request taken while previous one in progress");

    // A read entry always carries a stored, in-range priority.
    a_read_priority: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == RESP_READ) |-> out_ch.entry_priority != '0)
        else $error("read entry with zero priority");

    // Answers other than a read entry carry zero entry fields and end the item.
    a_answer_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != RESP_READ) |->
            (out_ch.entry_priority == '0 && out_ch.entry_time == '0 && out_ch.last))
        else $error("non-read answer with entry data");

    // No entry is stored into a full level.
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.place_above || cmd.place_at) |-> !sts.full)
        else $error("insert into full level");

endmodule
`default_nettype wire

/* hdl/mlsq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlsq_ctrl
// Controller state machine: sequences sorted inserts and level readouts.
// ----------------------------------------------------------------------------
module mlsq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire mlsq_pkg::sts_t sts,
    output mlsq_pkg::cmd_t      cmd
);
    import mlsq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.is_insert)
                begin
                    if (!sts.lvl_ok || sts.full)
                    begin
                        state_next = S_RESP;
                    end
                    else if (sts.empty)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        cmd.ins_first = 1'b1;
                        state_next    = S_INS_CMP;
                    end
                end
                else
                begin
                    if (!sts.lvl_ok || sts.empty)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.rd_first = 1'b1;
                        state_next   = S_RD_EMIT;
                    end
                end
            end
            S_INS_CMP:
            begin
                // Walk from the tail, moving larger priorities up one slot.
                if (sts.greater)
                begin
                    cmd.shift = 1'b1;
                    if (sts.pos_zero)
                    begin
                        state_next = S_INS_PUT;
                    end
                end
                else
                begin
                    cmd.place_above = 1'b1;
                    state_next      = S_RESP;
                end
            end
            S_INS_PUT:
            begin
                cmd.place_at = 1'b1;
                state_next   = S_RESP;
            end
            S_RD_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.rd_emit = 1'b1;
                    if (sts.rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.resp_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hdl/mlsq_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlsq_dpath
// Datapath: entry memory, per-level fill counts, walk position and the
// result output register.
// ----------------------------------------------------------------------------
module mlsq_dpath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mlsq_pkg::cmd_t                  cmd,
    output mlsq_pkg::sts_t                       sts,
    input  wire logic                            in_action,
    input  wire logic [mlsq_pkg::PRI_W-1:0]      in_priority,
    input  wire logic [mlsq_pkg::TIME_IN_W-1:0]  in_time,
    input  wire logic [mlsq_pkg::LEVEL_IN_W-1:0] in_level,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [mlsq_pkg::STATUS_W-1:0]        out_status,
    output logic [mlsq_pkg::PRI_W-1:0]           out_priority,
    output logic [mlsq_pkg::TIME_IN_W-1:0]       out_time,
    output logic                                 out_last
);
    import mlsq_pkg::*;

    // Item registers.
    logic              act_reg;
    logic [PRI_W-1:0]  pri_reg;
    logic [TW-1:0]     time_reg;
    logic [LV_W-1:0]   lvl_reg;
    logic              lvl_ok_reg;
    resp_t             code_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  cnt_reg [LEVELS];

    // Entry memory with registered read data.
    logic [MEM_W-1:0]  mem [DEPTH];
    logic [MEM_W-1:0]  rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [MEM_W-1:0]  wr_data;

    // Output register.
    logic                out_valid_reg;
    resp_t               out_status_reg;
    logic [PRI_W-1:0]    out_pri_reg;
    logic [TW-1:0]       out_time_reg;
    logic                out_last_reg;

    logic [CNT_W-1:0]  cur_cnt;
    logic [CNT_W-1:0]  in_cnt;
    lvl_sel_t          in_sel;
    logic [LV_W-1:0]   in_lv;
    logic              in_lv_ok;
    logic [PRI_W-1:0]  rd_pri;
    logic [TW-1:0]     rd_time;
    logic [MEM_W-1:0]  new_entry;
    logic [POS_W-1:0]  pos_up;
    logic [POS_W-1:0]  pos_dn;
    logic              rd_last;
    logic              out_free;
    logic              place;

    // Address of slot pos within level lv.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LV_W-1:0]  lv,
                                                    input logic [POS_W-1:0] pos);
        return ADDR_W'(ADDR_W'(lv) * ADDR_W'(CAPACITY)) + ADDR_W'(pos);
    endfunction

    // Level and fill count of the incoming item, and fill count of the captured level.
    always_comb
    begin
        in_sel = level_of(in_priority);
        if (in_action == ACT_INSERT)
        begin
            in_lv    = in_sel.lv;
            in_lv_ok = in_sel.ok;
        end
        else
        begin
            in_lv    = LV_W'(in_level);
            in_lv_ok = (int'(in_level) < LEVELS);
        end
        in_cnt  = '0;
        cur_cnt = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (in_lv == LV_W'(l))
            begin
                in_cnt = cnt_reg[l];
            end
            if (lvl_reg == LV_W'(l))
            begin
                cur_cnt = cnt_reg[l];
            end
        end
    end

    // Common datapath terms.
    assign rd_pri    = rd_data_reg[MEM_W-1 -: PRI_W];
    assign rd_time   = rd_data_reg[TW-1:0];
    assign new_entry = {pri_reg, time_reg};
    assign pos_up    = pos_reg + POS_W'(1);
    assign pos_dn    = pos_reg - POS_W'(1);
    assign rd_last   = (CNT_W'(pos_reg) + CNT_W'(1)) == cur_cnt;
    assign out_free  = !out_valid_reg || out_ready;
    assign place     = cmd.place_above || cmd.place_at;

    // Status to the controller.
    always_comb
    begin
        sts.is_insert = (act_reg == ACT_INSERT);
        sts.lvl_ok    = lvl_ok_reg;
        sts.full      = (cur_cnt >= CNT_W'(CAPACITY));
        sts.empty     = (cur_cnt == '0);
        sts.greater   = (rd_pri > pri_reg);
        sts.pos_zero  = (pos_reg == '0);
        sts.rd_last   = rd_last;
        sts.out_free  = out_free;
    end

    // Memory port selection.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = slot_addr(lvl_reg, '0);
        wr_en   = 1'b0;
        wr_addr = slot_addr(lvl_reg, pos_up);
        wr_data = new_entry;
        if (cmd.ins_first)
        begin
            rd_en   = 1'b1;
            rd_addr = slot_addr(lvl_reg, POS_W'(cur_cnt - CNT_W'(1)));
        end
        if (cmd.shift)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg;
            if (pos_reg != '0)
            begin
                rd_en   = 1'b1;
                rd_addr = slot_addr(lvl_reg, pos_dn);
            end
        end
        if (cmd.place_above)
        begin
            wr_en = 1'b1;
        end
        if (cmd.place_at)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_addr(lvl_reg, pos_reg);
        end
        if (cmd.rd_first)
        begin
            rd_en = 1'b1;
        end
        if (cmd.rd_emit && !rd_last)
        begin
            rd_en   = 1'b1;
            rd_addr = slot_addr(lvl_reg, pos_up);
        end
    end

    // Entry memory.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Item capture and walk position.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg    <= in_action;
            pri_reg    <= in_priority;
            time_reg   <= in_time[TW-1:0];
            lvl_reg    <= in_lv;
            lvl_ok_reg <= in_lv_ok;
            if (in_action == ACT_READOUT)
            begin
                code_reg <= RESP_EMPTY;
            end
            else if (!in_lv_ok)
            begin
                code_reg <= RESP_RANGE;
            end
            else if (in_cnt >= CNT_W'(CAPACITY))
            begin
                code_reg <= RESP_FULL;
            end
            else
            begin
                code_reg <= RESP_ADDED;
            end
            pos_reg <= '0;
        end
        else if (cmd.ins_first)
        begin
            pos_reg <= POS_W'(cur_cnt - CNT_W'(1));
        end
        else if (cmd.shift && pos_reg != '0)
        begin
            pos_reg <= pos_dn;
        end
        else if (cmd.rd_emit && !rd_last)
        begin
            pos_reg <= pos_up;
        end
    end

    // Per-level fill counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                cnt_reg[l] <= '0;
            end
        end
        else if (place)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                if (lvl_reg == LV_W'(l))
                begin
                    cnt_reg[l] <= cnt_reg[l] + CNT_W'(1);
                end
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.rd_emit || cmd.resp_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_emit)
        begin
            out_status_reg <= RESP_READ;
            out_pri_reg    <= rd_pri;
            out_time_reg   <= rd_time;
            out_last_reg   <= rd_last;
        end
        else if (cmd.resp_emit)
        begin
            out_status_reg <= code_reg;
            out_pri_reg    <= '0;
            out_time_reg   <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_priority = out_pri_reg;
    assign out_time     = TIME_IN_W'(out_time_reg);
    assign out_last     = out_last_reg;

endmodule
`default_nettype wire

/* sim/tb_multilevel_sorted_ready_queue_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multilevel_sorted_ready_queue_top
// Drives insert and readout requests into the three-level sorted ready
// queue through its request channel. Every request is run through a local
// copy of the queue levels, and every result on the result channel is
// compared in order with the predicted one. The sender works in bursts with
// gaps, and the result side stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_multilevel_sorted_ready_queue_top;

    import mlsq_pkg::*;

    localparam int  RANDOM_ITEMS = 335;
    localparam int  TAIL_CYCLES  = 24;
    localparam real RUN_LIMIT_NS = 5_000_000.0;

    // One predicted result of the queue.
    typedef struct packed {
        resp_t                status;
        logic [PRI_W-1:0]     pri;
        logic [TIME_IN_W-1:0] ctime;
        logic                 last;
    } queue_result_t;

    // Local copy of the queue levels and the results still to come.
    class ready_queue_scoreboard;
        logic [PRI_W-1:0] pri_store  [LEVELS][CAPACITY];
        logic [TW-1:0]    ctime_store[LEVELS][CAPACITY];
        int               fill       [LEVELS];
        queue_result_t    pending[$];
        int               mismatches;

        function new();
            for (int l = 0; l < LEVELS; l++)
            begin
                fill[l] = 0;
                for (int e = 0; e < CAPACITY; e++)
                begin
                    pri_store[l][e]   = '0;
                    ctime_store[l][e] = '0;
                end
            end
            mismatches = 0;
        endfunction

        // Level that a priority belongs to, or -1 when it fits none.
        function int band_of(logic [PRI_W-1:0] pri);
            int lv;
            if (pri >= BAND0_LO && pri <= BAND0_HI)
                lv = 0;
            else if (pri >= BAND1_LO && pri <= BAND1_HI)
                lv = 1;
            else if (pri >= BAND2_LO && pri <= BAND2_HI)
                lv = 2;
            else
                lv = -1;
            if (lv >= LEVELS)
                lv = -1;
            return lv;
        endfunction

        function void push_result(resp_t st, logic [PRI_W-1:0] pri,
                                  logic [TIME_IN_W-1:0] ctime, logic last);
            queue_result_t r;
            r.status = st;
            r.pri    = pri;
            r.ctime  = ctime;
            r.last   = last;
            pending.push_back(r);
        endfunction

        // Apply one accepted request and queue the results it causes.
        function void note_request(action_t act, logic [PRI_W-1:0] pri,
                                   logic [TIME_IN_W-1:0] ctime,
                                   logic [LEVEL_IN_W-1:0] lvl);
            int lv;
            int n;
            int pos;
            if (act == ACT_INSERT)
            begin
                lv = band_of(pri);
                if (lv < 0)
                begin
                    push_result(RESP_RANGE, '0, '0, 1'b1);
                    return;
                end
                n = fill[lv];
                if (n >= CAPACITY)
                begin
                    push_result(RESP_FULL, '0, '0, 1'b1);
                    return;
                end
                // Equal priorities keep their arrival order.
                pos = 0;
                while (pos < n && pri_store[lv][pos] <= pri)
                    pos++;
                for (int i = n; i > pos; i--)
                begin
                    pri_store[lv][i]   = pri_store[lv][i-1];
                    ctime_store[lv][i] = ctime_store[lv][i-1];
                end
                pri_store[lv][pos]   = pri;
                ctime_store[lv][pos] = ctime[TW-1:0];
                fill[lv]             = n + 1;
                push_result(RESP_ADDED, '0, '0, 1'b1);
            end
            else
            begin
                if (int'(lvl) >= LEVELS || fill[lvl] == 0)
                begin
                    push_result(RESP_EMPTY, '0, '0, 1'b1);
                    return;
                end
                n = fill[lvl];
                for (int i = 0; i < n; i++)
                    push_result(RESP_READ, pri_store[lvl][i],
                                TIME_IN_W'(ctime_store[lvl][i]), i == n - 1);
            end
        endfunction

        function void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
            if (expv !== actv)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, expv, actv);
            end
        endfunction

        // Compare one result transfer with the oldest prediction.
        function void check_result(logic [STATUS_W-1:0] st, logic [PRI_W-1:0] pri,
                                   logic [TIME_IN_W-1:0] ctime, logic last);
            queue_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                         $time, st, pri, ctime, last);
                return;
            end
            want = pending.pop_front();
            compare_field("status", 32'(want.status), 32'(st));
            compare_field("entry_priority", 32'(want.pri), 32'(pri));
            compare_field("entry_time", 32'(want.ctime), 32'(ctime));
            compare_field("last", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mlsq_in_if  in_ch ();
    mlsq_out_if out_ch ();

    ready_queue_scoreboard sb = new();
    int burst_left = 0;

    multilevel_sorted_ready_queue_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Free-running clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Present one request, honoring the burst and gap pattern, and wait for
    // its transfer.
    task automatic send_request(action_t act, logic [PRI_W-1:0] pri,
                                logic [TIME_IN_W-1:0] ctime,
                                logic [LEVEL_IN_W-1:0] lvl);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(15, 40);
            else if ($urandom_range(0, 2) == 0)
                gap = 0;
            else
                gap = $urandom_range(1, 7);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.priority_req <= pri;
        in_ch.exec_time    <= ctime;
        in_ch.level        <= lvl;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        burst_left--;
        sb.note_request(act, pri, ctime, lvl);
    endtask

    task automatic send_insert(logic [PRI_W-1:0] pri, logic [TIME_IN_W-1:0] ctime);
        send_request(ACT_INSERT, pri, ctime, LEVEL_IN_W'($urandom));
    endtask

    task automatic send_readout(logic [LEVEL_IN_W-1:0] lvl);
        send_request(ACT_READOUT, PRI_W'($urandom), TIME_IN_W'($urandom), lvl);
    endtask

    // Hold the request channel idle until every predicted result is in.
    task automatic wait_for_drain();
        if (in_ch.valid)
            in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() > 0)
            @(posedge clk);
    endtask

    // Mostly well-formed inserts and readouts, with some out-of-range noise.
    task automatic send_random_request();
        logic [PRI_W-1:0] pri;
        if ($urandom_range(0, 99) < 40)
        begin
            send_readout(LEVEL_IN_W'($urandom));
        end
        else
        begin
            if ($urandom_range(0, 99) < 85)
                pri = PRI_W'($urandom_range(BAND0_LO, BAND2_HI));
            else
                pri = PRI_W'($urandom);
            send_insert(pri, TIME_IN_W'($urandom));
        end
    endtask

    // Result side: check each transfer and stall in changing patterns.
    initial
    begin : result_sink
        int mode;
        int span;
        mode = 0;
        span = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.status, out_ch.entry_priority,
                                out_ch.entry_time, out_ch.last);
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 80);
            end
            span--;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= (span % 4 == 0);
                default: out_ch.ready <= $urandom_range(0, 1);
            endcase
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        in_ch.valid        <= 1'b0;
        in_ch.action       <= ACT_INSERT;
        in_ch.priority_req <= '0;
        in_ch.exec_time    <= '0;
        in_ch.level        <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty and missing levels, range limits, band edges,
        // equal priorities, then an ordered readout of each level.
        send_readout(2'd0);
        send_readout(2'd3);
        send_insert(5'd0, 8'd12);
        send_insert(5'd31, 8'd34);
        send_insert(5'd1, 8'd0);
        send_insert(5'd10, 8'd255);
        send_insert(5'd11, 8'hAA);
        send_insert(5'd20, 8'h55);
        send_insert(5'd21, 8'd1);
        send_insert(5'd30, 8'h80);
        send_insert(5'd5, 8'd7);
        send_insert(5'd5, 8'd9);
        send_insert(5'd1, 8'd3);
        send_insert(5'd30, 8'h7F);
        send_readout(2'd0);
        send_readout(2'd1);
        send_readout(2'd2);
        send_readout(2'd3);
        wait_for_drain();

        // Fill the top level past its capacity, then read it back.
        for (int k = 0; k < CAPACITY; k++)
            send_insert(PRI_W'($urandom_range(BAND2_LO, BAND2_HI)), TIME_IN_W'($urandom));
        send_readout(2'd2);
        wait_for_drain();

        // Random mix, with the occasional full drain.
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            send_random_request();
            if ($urandom_range(0, 49) == 0)
                wait_for_drain();
        end
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard limit on the run time.
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("timeout with %0d results outstanding", sb.pending.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* multilevel_sorted_ready_queue_top.f */
hdl/mlsq_pkg.sv
hdl/mlsq_if.sv
hdl/mlsq_ctrl.sv
hdl/mlsq_dpath.sv
hdl/multilevel_sorted_ready_queue_top.sv
sim/tb_multilevel_sorted_ready_queue_top.sv
